[rtl/hat_pkg.sv]
// Shared types and constants for the heater auto-off timer.
// Used by every module of the block; has no dependencies of its own.
package hat_pkg;

  // Field widths.
  localparam int TIME_W = 63;
  localparam int MIN_W  = 16;
  // A duration of up to 65536 minutes in microseconds fits in 42 bits.
  localparam int NUM_W  = 42;

  // One minute in microseconds, and the limits used for rounding up.
  localparam logic [NUM_W-1:0]  US_PER_MIN    = 42'd60000000;
  localparam logic [NUM_W-1:0]  US_PER_MIN_M1 = 42'd59999999;
  // 65535 minutes in microseconds: a longer wait saturates the minute count.
  localparam logic [TIME_W-1:0] SAT_DIFF      = 63'd3932100000000;
  localparam logic [NUM_W-1:0]  SAT_NUM       = 42'd3932100000000;

  // Division by one minute. The numerator is first shifted down by 8 bits,
  // which leaves a divisor of 234375. The quotient is estimated from the top
  // 24 numerator bits with a reciprocal scaled by 2^26; the estimate is never
  // high and is low by at most one, so one compare finishes the division.
  localparam int          SCL_SH   = 8;
  localparam int          SCL_W    = NUM_W - SCL_SH;
  localparam int          HI_SH    = 18;
  localparam int          RECIP_SH = 26;
  localparam int          EST_W    = 43;
  localparam logic [17:0] MIN_SCL  = 18'd234375;
  localparam logic [18:0] RECIP    = 19'd293203;

  // Operation codes.
  localparam logic [1:0] OP_CHECK     = 2'd0;
  localparam logic [1:0] OP_SET_HEAT  = 2'd1;
  localparam logic [1:0] OP_SET_TIMER = 2'd2;
  localparam logic [1:0] OP_STATUS    = 2'd3;

  // Switch-off reasons.
  localparam logic [1:0] REASON_NONE   = 2'd0;
  localparam logic [1:0] REASON_USER   = 2'd1;
  localparam logic [1:0] REASON_SAFETY = 2'd2;

  // Configuration register indexes.
  localparam logic REG_SAFETY_ENABLE  = 1'b0;
  localparam logic REG_SAFETY_MINUTES = 1'b1;

  // Result flags that travel unchanged to the output.
  typedef struct packed {
    logic       heating;
    logic [1:0] reason;
    logic       armed;
  } hat_flags_t;

  // State snapshot after one request, handed to the remaining-time pipeline.
  typedef struct packed {
    hat_flags_t        flags;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] user_dl;
    logic [TIME_W-1:0] safety_dl;
    logic              safety_on;
  } hat_ev_t;

  // Rounded-up numerator ready for division by one minute.
  typedef struct packed {
    hat_flags_t       flags;
    logic             rvalid;
    logic [NUM_W-1:0] num;
  } hat_num_t;

  // Final result of one request.
  typedef struct packed {
    hat_flags_t       flags;
    logic             rvalid;
    logic [MIN_W-1:0] minutes;
  } hat_res_t;

endpackage

[rtl/hat_ctrl.sv]
// Input register, heating state and configuration registers of the auto-off timer.
// Resolves each request against the state combinationally from the input register.
// Depends on hat_pkg.
module hat_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [79:0]              s_axis_tdata,
  input  logic [1:0]               s_axis_tuser,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [15:0]              cfg_data,
  output hat_pkg::hat_ev_t         ev,
  output logic                     ev_valid,
  input  logic                     ev_ready
);

  // Saturating add of a duration to a time stamp.
  function automatic logic [hat_pkg::TIME_W-1:0] sat_add(
    input logic [hat_pkg::TIME_W-1:0] t,
    input logic [hat_pkg::NUM_W-1:0]  d
  );
    logic [hat_pkg::TIME_W:0] s;
    s = {1'b0, t} + (hat_pkg::TIME_W+1)'(d);
    return s[hat_pkg::TIME_W] ? '1 : s[hat_pkg::TIME_W-1:0];
  endfunction

  // Input register.
  logic                         ir_v;
  logic [1:0]                   ir_op;
  logic [hat_pkg::TIME_W-1:0]   ir_now;
  logic                         ir_req;
  logic [hat_pkg::MIN_W-1:0]    ir_mins;
  logic [hat_pkg::NUM_W-1:0]    ir_mins_us;

  // Configuration.
  logic                         safety_en;
  logic [hat_pkg::NUM_W-1:0]    safety_us;

  // Heating state.
  logic                         heating;
  logic [hat_pkg::MIN_W-1:0]    timer_min;
  logic [hat_pkg::NUM_W-1:0]    timer_us;
  logic [hat_pkg::TIME_W-1:0]   start_time;
  logic [hat_pkg::TIME_W-1:0]   user_dl;
  logic [hat_pkg::TIME_W-1:0]   safety_dl;

  logic                         heating_next;
  logic [hat_pkg::MIN_W-1:0]    timer_min_next;
  logic [hat_pkg::NUM_W-1:0]    timer_us_next;
  logic [hat_pkg::TIME_W-1:0]   start_time_next;
  logic [hat_pkg::TIME_W-1:0]   user_dl_next;
  logic [1:0]                   reason;

  logic                         accept;
  logic                         fire;
  logic                         safety_on;
  logic                         user_wins;
  logic [hat_pkg::TIME_W-1:0]   dl;
  logic                         expire;
  logic                         turn_on;
  logic [hat_pkg::TIME_W-1:0]   user_sum;
  logic [hat_pkg::TIME_W-1:0]   safety_sum;

  // New requests wait while a configuration write is presented.
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = ir_v && ev_ready;
  assign s_axis_tready = (!ir_v || ev_ready) && !cfg_valid;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_v <= 1'b0;
    end else if (accept) begin
      ir_v <= 1'b1;
    end else if (ev_ready) begin
      ir_v <= 1'b0;
    end
  end

  // The timer duration is multiplied out on the way into the input register.
  always_ff @(posedge clk) begin
    if (accept) begin
      ir_op      <= s_axis_tuser;
      ir_now     <= s_axis_tdata[62:0];
      ir_req     <= s_axis_tdata[63];
      ir_mins    <= s_axis_tdata[79:64];
      ir_mins_us <= hat_pkg::NUM_W'(s_axis_tdata[79:64]) * hat_pkg::US_PER_MIN;
    end
  end

  // Configuration writes; the safety limit is kept in microseconds.
  always_ff @(posedge clk) begin
    if (rst) begin
      safety_en <= 1'b0;
      safety_us <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hat_pkg::REG_SAFETY_ENABLE:  safety_en <= cfg_data[0];
        hat_pkg::REG_SAFETY_MINUTES: safety_us <= hat_pkg::NUM_W'(cfg_data) * hat_pkg::US_PER_MIN;
        default: ;
      endcase
    end
  end

  // Effective deadline from the current state and the expiry decision.
  assign safety_on = safety_en && (|start_time) && (|safety_us);
  assign user_wins = (|user_dl) && (!safety_on || user_dl <= safety_dl);
  assign dl        = user_wins ? user_dl : (safety_on ? safety_dl : '0);
  assign expire    = (ir_op == hat_pkg::OP_CHECK) && heating && (|dl) && (ir_now >= dl);
  assign turn_on   = (ir_op == hat_pkg::OP_SET_HEAT) && ir_req && !heating;

  // Deadline adders: one for the user timer, one for the safety limit.
  assign user_sum   = sat_add(ir_now, (ir_op == hat_pkg::OP_SET_TIMER) ? ir_mins_us : timer_us);
  assign safety_sum = sat_add(ir_v ? ir_now : start_time, safety_us);

  // Next state for the request in the input register.
  always_comb begin
    heating_next    = heating;
    timer_min_next  = timer_min;
    timer_us_next   = timer_us;
    start_time_next = start_time;
    user_dl_next    = user_dl;
    reason          = hat_pkg::REASON_NONE;
    unique case (ir_op)
      hat_pkg::OP_CHECK: begin
        if (expire) begin
          reason          = user_wins ? hat_pkg::REASON_USER : hat_pkg::REASON_SAFETY;
          heating_next    = 1'b0;
          start_time_next = '0;
          user_dl_next    = '0;
        end
      end
      hat_pkg::OP_SET_HEAT: begin
        heating_next = ir_req;
        if (!ir_req) begin
          start_time_next = '0;
          user_dl_next    = '0;
        end else if (!heating) begin
          start_time_next = ir_now;
          user_dl_next    = (|timer_min) ? user_sum : '0;
        end
      end
      hat_pkg::OP_SET_TIMER: begin
        timer_min_next = ir_mins;
        timer_us_next  = ir_mins_us;
        user_dl_next   = (heating && (|ir_mins)) ? user_sum : '0;
      end
      hat_pkg::OP_STATUS: ;
      default: ;
    endcase
  end

  // State update when the request moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      heating    <= 1'b0;
      timer_min  <= '0;
      timer_us   <= '0;
      start_time <= '0;
      user_dl    <= '0;
    end else if (fire) begin
      heating    <= heating_next;
      timer_min  <= timer_min_next;
      timer_us   <= timer_us_next;
      start_time <= start_time_next;
      user_dl    <= user_dl_next;
    end
  end

  // The safety deadline is refreshed whenever no request is waiting, which
  // picks up a new safety limit before the next request is resolved.
  always_ff @(posedge clk) begin
    if (rst) begin
      safety_dl <= '0;
    end else if (fire) begin
      if (turn_on) begin
        safety_dl <= safety_sum;
      end
    end else if (!ir_v) begin
      safety_dl <= safety_sum;
    end
  end

  // Snapshot of the state after this request.
  assign ev_valid            = ir_v;
  assign ev.flags.heating    = heating_next;
  assign ev.flags.reason     = reason;
  assign ev.flags.armed      = |timer_min_next;
  assign ev.now              = ir_now;
  assign ev.user_dl          = user_dl_next;
  assign ev.safety_dl        = turn_on ? safety_sum : safety_dl;
  assign ev.safety_on        = safety_en && (|start_time_next) && (|safety_us);

endmodule

[rtl/hat_rem.sv]
// Remaining-time preparation: effective deadline, time left, and the
// rounded-up numerator for the minute divider. Depends on hat_pkg.
module hat_rem (
  input  logic               clk,
  input  logic               rst,
  input  hat_pkg::hat_ev_t   ev,
  input  logic               ev_valid,
  output logic               ev_ready,
  output hat_pkg::hat_num_t  num,
  output logic               num_valid,
  input  logic               num_ready
);

  // Stage 1: state snapshot.
  logic                         v1;
  hat_pkg::hat_ev_t             s1;
  // Stage 2: effective deadline.
  logic                         v2;
  hat_pkg::hat_flags_t          s2_flags;
  logic                         s2_rvalid;
  logic [hat_pkg::TIME_W-1:0]   s2_now;
  logic [hat_pkg::TIME_W-1:0]   s2_eff;
  // Stage 3: time left.
  logic                         v3;
  hat_pkg::hat_flags_t          s3_flags;
  logic                         s3_rvalid;
  logic                         s3_live;
  logic [hat_pkg::TIME_W-1:0]   s3_diff;
  // Stage 4: numerator.
  logic                         v4;

  logic                         ld1, ld2, ld3, ld4;
  logic [hat_pkg::TIME_W-1:0]   eff;
  logic [hat_pkg::TIME_W:0]     diff_full;
  logic [hat_pkg::NUM_W-1:0]    num_next;

  assign ld4      = !v4 || num_ready;
  assign ld3      = !v3 || ld4;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign ev_ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= ev_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  // Earlier of the two deadlines; zero means none.
  always_comb begin
    if (s1.user_dl == '0) begin
      eff = s1.safety_on ? s1.safety_dl : '0;
    end else if (s1.safety_on && s1.safety_dl < s1.user_dl) begin
      eff = s1.safety_dl;
    end else begin
      eff = s1.user_dl;
    end
  end

  // Time left; only a deadline still in the future counts.
  assign diff_full = {1'b0, s2_eff} - {1'b0, s2_now};

  // Numerator rounded up, forced to the saturation value or to zero.
  always_comb begin
    if (!s3_live) begin
      num_next = '0;
    end else if (s3_diff > hat_pkg::SAT_DIFF) begin
      num_next = hat_pkg::SAT_NUM;
    end else begin
      num_next = s3_diff[hat_pkg::NUM_W-1:0] + hat_pkg::US_PER_MIN_M1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1 <= ev;
    end
    if (ld2) begin
      s2_flags  <= s1.flags;
      s2_rvalid <= s1.flags.heating && (|eff);
      s2_now    <= s1.now;
      s2_eff    <= eff;
    end
    if (ld3) begin
      s3_flags  <= s2_flags;
      s3_rvalid <= s2_rvalid;
      s3_live   <= s2_rvalid && !diff_full[hat_pkg::TIME_W] &&
                   (|diff_full[hat_pkg::TIME_W-1:0]);
      s3_diff   <= diff_full[hat_pkg::TIME_W-1:0];
    end
    if (ld4) begin
      num.flags  <= s3_flags;
      num.rvalid <= s3_rvalid;
      num.num    <= num_next;
    end
  end

  assign num_valid = v4;

endmodule

[rtl/hat_div.sv]
// Pipelined division of the rounded-up numerator by one minute.
// Reciprocal estimate, bound of the next quotient value, then the result register.
// Depends on hat_pkg.
module hat_div (
  input  logic               clk,
  input  logic               rst,
  input  hat_pkg::hat_num_t  num,
  input  logic               num_valid,
  output logic               num_ready,
  output hat_pkg::hat_res_t  res,
  output logic               res_valid,
  input  logic               res_ready
);

  // Stage 1: quotient estimate.
  logic                         v1;
  hat_pkg::hat_flags_t          s1_flags;
  logic                         s1_rvalid;
  logic [hat_pkg::SCL_W-1:0]    s1_x;
  logic [hat_pkg::MIN_W-1:0]    s1_q;
  // Stage 2: lowest scaled numerator that gives the next quotient value.
  logic                         v2;
  hat_pkg::hat_flags_t          s2_flags;
  logic                         s2_rvalid;
  logic [hat_pkg::SCL_W-1:0]    s2_x;
  logic [hat_pkg::MIN_W-1:0]    s2_q;
  logic [hat_pkg::SCL_W-1:0]    s2_lim;
  // Stage 3 is the result register.
  logic                         v3;

  logic                         ld1, ld2, ld3;
  logic [hat_pkg::EST_W-1:0]    est;
  logic [hat_pkg::SCL_W-1:0]    lim_next;

  assign ld3       = !v3 || res_ready;
  assign ld2       = !v2 || ld3;
  assign ld1       = !v1 || ld2;
  assign num_ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) v1 <= num_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  // Reciprocal multiplication on the top numerator bits.
  assign est = hat_pkg::EST_W'(num.num[hat_pkg::NUM_W-1:hat_pkg::HI_SH]) *
               hat_pkg::EST_W'(hat_pkg::RECIP);

  // (estimate + 1) times the scaled divisor.
  assign lim_next = hat_pkg::SCL_W'(s1_q) * hat_pkg::SCL_W'(hat_pkg::MIN_SCL) +
                    hat_pkg::SCL_W'(hat_pkg::MIN_SCL);

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_flags  <= num.flags;
      s1_rvalid <= num.rvalid;
      s1_x      <= num.num[hat_pkg::NUM_W-1:hat_pkg::SCL_SH];
      s1_q      <= est[hat_pkg::RECIP_SH+hat_pkg::MIN_W-1:hat_pkg::RECIP_SH];
    end
    if (ld2) begin
      s2_flags  <= s1_flags;
      s2_rvalid <= s1_rvalid;
      s2_x      <= s1_x;
      s2_q      <= s1_q;
      s2_lim    <= lim_next;
    end
    // The estimate is raised by one when the numerator reaches the next bound.
    if (ld3) begin
      res.flags   <= s2_flags;
      res.rvalid  <= s2_rvalid;
      res.minutes <= (s2_x >= s2_lim) ? s2_q + 16'd1 : s2_q;
    end
  end

  assign res_valid = v3;

endmodule

[rtl/heater_auto_off_timer.sv]
// Top level of the heater auto-off timer: request stream in, status stream out.
// Instantiates hat_ctrl, hat_rem and hat_div; depends on hat_pkg.

// The block takes one request per clock while s_axis_tready is high and returns
// one status item per request, in order. Each request is resolved against the
// heating state combinationally in the control stage, which is what allows a
// new request in every cycle; the minutes-left figure is then worked out in a
// pipeline of four preparation stages and three divider stages, where the
// division by one minute is a reciprocal multiplication followed by a single
// correction step. Up to eight requests can be held inside at once, and
// s_axis_tready stays high while a finished result waits as long as a pipeline
// stage is free. s_axis_tready is low in any cycle in which cfg_valid is high;
// configuration writes are taken at once. Registers are meant to be written
// while no request is in flight; a request taken at any later edge then sees
// the new values.
module heater_auto_off_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_us [62:0], heat_request [63], new_timer_minutes [79:64]
  input  logic [79:0] s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // heating_active [0], off_reason [2:1], timer_armed [3], remaining_valid [4],
  // remaining_minutes [20:5], zero [23:21]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  hat_pkg::hat_ev_t  ev;
  logic              ev_valid;
  logic              ev_ready;
  hat_pkg::hat_num_t num;
  logic              num_valid;
  logic              num_ready;
  hat_pkg::hat_res_t res;

  // Request register, state and configuration.
  hat_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ev            (ev),
    .ev_valid      (ev_valid),
    .ev_ready      (ev_ready)
  );

  // Effective deadline and rounded numerator.
  hat_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .ev        (ev),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .num       (num),
    .num_valid (num_valid),
    .num_ready (num_ready)
  );

  // Minute divider and result register.
  hat_div u_div (
    .clk       (clk),
    .rst       (rst),
    .num       (num),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .res       (res),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, res.minutes, res.rvalid, res.flags.armed,
                         res.flags.reason, res.flags.heating};

endmodule

[rtl/hat_checker.sv]
// Port-level checks for the heater auto-off timer, bound to the top level.
// Depends on hat_pkg for the reason codes.
module hat_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A held result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A reported switch-off leaves heating off.
  a_reason_off: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[2:1] != hat_pkg::REASON_NONE) |-> !m_axis_tdata[0])
    else $error("switch-off reason reported with heating on");

  // Remaining time is only valid while heating.
  a_rvalid_heat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0])
    else $error("remaining time valid with heating off");

  // Without a valid deadline the minute count is zero.
  a_rem_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[4] |-> (m_axis_tdata[20:5] == 16'd0))
    else $error("remaining minutes nonzero without a deadline");

endmodule

bind heater_auto_off_timer hat_checker u_hat_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the heater auto-off timer (heater_auto_off_timer).
// Streams requests, writes the safety registers between phases and checks every status
// item against a behavioral model kept here; depends on hat_pkg and the RTL.
module testbench;

  localparam logic [62:0] T_MAX       = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_US      = 64'd60000000;
  localparam int          IDLE_PCT    = 13;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          MAX_REPORTS = 10;

  // Status item in field order; heating is the top bit of the packed form.
  typedef struct packed {
    logic        heating;
    logic [1:0]  reason;
    logic        armed;
    logic        rem_valid;
    logic [15:0] rem_min;
  } status_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // now_us [62:0], heat_request [63], new_timer_minutes [79:64]
  logic [79:0] s_axis_tdata  = '0;
  // operation [1:0]
  logic [1:0]  s_axis_tuser  = hat_pkg::OP_STATUS;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // heating_active [0], off_reason [2:1], timer_armed [3], remaining_valid [4],
  // remaining_minutes [20:5], zero [23:21]
  logic [23:0] m_axis_tdata;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic        cfg_index     = hat_pkg::REG_SAFETY_ENABLE;
  logic [15:0] cfg_data      = '0;

  // Model state of the timer and its registers.
  logic        safety_en  = 1'b0;
  logic [15:0] safety_min = '0;
  logic        heat_on    = 1'b0;
  logic [15:0] timer_min  = '0;
  logic [62:0] start_t    = '0;
  logic [62:0] user_dl    = '0;

  status_t     expected_status[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  bit          steady         = 1'b0;
  logic [62:0] now_us         = '0;

  heater_auto_off_timer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Time plus a span, held at the largest 63-bit value.
  function automatic logic [62:0] later(input logic [62:0] t, input logic [63:0] span);
    logic [63:0] sum;
    sum = {1'b0, t} + span;
    return (sum > {1'b0, T_MAX}) ? T_MAX : sum[62:0];
  endfunction

  function automatic logic [62:0] safety_deadline();
    if (safety_en && start_t != 0 && safety_min != 0) begin
      return later(start_t, 64'(safety_min) * MIN_US);
    end
    return '0;
  endfunction

  // The earlier of the two deadlines; zero stands for no deadline.
  function automatic logic [62:0] nearest_deadline();
    logic [62:0] dl;
    logic [62:0] sdl;
    dl  = user_dl;
    sdl = safety_deadline();
    if (sdl != 0 && (dl == 0 || sdl < dl)) begin
      dl = sdl;
    end
    return dl;
  endfunction

  // Apply one request to the model state and return the status it produces.
  function automatic status_t apply_request(input logic [1:0] op, input logic [62:0] now,
                                            input logic req, input logic [15:0] mins);
    status_t     st;
    logic [62:0] dl;
    logic [63:0] q;
    st = '0;
    case (op)
      hat_pkg::OP_CHECK: begin
        if (heat_on) begin
          dl = nearest_deadline();
          if (dl != 0 && now >= dl) begin
            st.reason = (user_dl != 0 && user_dl <= dl) ? hat_pkg::REASON_USER
                                                        : hat_pkg::REASON_SAFETY;
            heat_on   = 1'b0;
            start_t   = '0;
            user_dl   = '0;
          end
        end
      end
      hat_pkg::OP_SET_HEAT: begin
        if (!req) begin
          start_t = '0;
          user_dl = '0;
        end else if (!heat_on) begin
          start_t = now;
          user_dl = (timer_min != 0) ? later(now, 64'(timer_min) * MIN_US) : '0;
        end
        heat_on = req;
      end
      hat_pkg::OP_SET_TIMER: begin
        timer_min = mins;
        user_dl   = (heat_on && mins != 0) ? later(now, 64'(mins) * MIN_US) : '0;
      end
      default: begin
      end
    endcase
    // Minutes left, rounded up, after the request took effect.
    dl         = nearest_deadline();
    st.heating = heat_on;
    st.armed   = (timer_min != 0);
    if (heat_on && dl != 0) begin
      st.rem_valid = 1'b1;
      if (dl > now) begin
        q          = ({1'b0, dl} - {1'b0, now} + MIN_US - 64'd1) / MIN_US;
        st.rem_min = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
      end
    end
    return st;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Send one request, idling at random first; returns at the edge that took it.
  task automatic send_request(input logic [1:0] op, input logic [62:0] now,
                              input logic req, input logic [15:0] mins);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {mins, req, now};
    do @(posedge clk); while (!s_axis_tready);
    expected_status.push_back(apply_request(op, now, req, mins));
  endtask

  // Stop sending and wait for every outstanding status item.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == hat_pkg::REG_SAFETY_ENABLE) begin
      safety_en = value[0];
    end else begin
      safety_min = value;
    end
    // Leave a few quiet cycles after the write.
    repeat (3) @(posedge clk);
  endtask

  task automatic set_safety(input logic en, input logic [15:0] mins);
    wait_drained();
    write_register(hat_pkg::REG_SAFETY_ENABLE, {15'($urandom), en});
    write_register(hat_pkg::REG_SAFETY_MINUTES, mins);
  endtask

  // User timer alone: start at time zero, rounding, expiry, repeated on and off.
  task automatic test_user_timer();
    send_request(hat_pkg::OP_STATUS, 63'd0, 1'b1, 16'hFFFF);
    send_request(hat_pkg::OP_SET_TIMER, 63'd0, 1'b0, 16'd2);
    send_request(hat_pkg::OP_SET_HEAT, 63'd0, 1'b1, 16'd0);
    send_request(hat_pkg::OP_STATUS, 63'd60000000, 1'b0, 16'd0);
    send_request(hat_pkg::OP_SET_HEAT, 63'd61000000, 1'b1, 16'd7);
    send_request(hat_pkg::OP_CHECK, 63'd119999999, 1'b0, 16'd0);
    send_request(hat_pkg::OP_CHECK, 63'd120000000, 1'b1, 16'd0);
    send_request(hat_pkg::OP_SET_HEAT, 63'd121000000, 1'b0, 16'd0);
    send_request(hat_pkg::OP_SET_TIMER, 63'd122000000, 1'b0, 16'hFFFF);
    send_request(hat_pkg::OP_SET_HEAT, 63'd123000000, 1'b1, 16'd0);
    send_request(hat_pkg::OP_SET_TIMER, 63'd124000000, 1'b1, 16'd0);
    send_request(hat_pkg::OP_SET_TIMER, 63'd125000000, 1'b0, 16'd1);
    send_request(hat_pkg::OP_SET_HEAT, 63'd126000000, 1'b0, 16'd0);
  endtask

  // Safety limit: expiry by safety, equal deadlines, no safety after a start at zero.
  task automatic test_safety_limit();
    set_safety(1'b1, 16'd1);
    send_request(hat_pkg::OP_SET_TIMER, 63'd200000000, 1'b0, 16'd5);
    send_request(hat_pkg::OP_SET_HEAT, 63'd300000000, 1'b1, 16'd0);
    send_request(hat_pkg::OP_CHECK, 63'd360000000, 1'b0, 16'd0);
    send_request(hat_pkg::OP_SET_TIMER, 63'd400000000, 1'b0, 16'd1);
    send_request(hat_pkg::OP_SET_HEAT, 63'd401000000, 1'b1, 16'd0);
    send_request(hat_pkg::OP_CHECK, 63'd461000000, 1'b0, 16'd0);
    send_request(hat_pkg::OP_SET_HEAT, 63'd0, 1'b1, 16'd0);
    send_request(hat_pkg::OP_SET_HEAT, 63'd500000000, 1'b0, 16'd0);
  endtask

  // Deadline sums past the top of the time range saturate.
  task automatic test_saturation();
    set_safety(1'b1, 16'hFFFF);
    send_request(hat_pkg::OP_SET_TIMER, T_MAX - 63'd1000, 1'b0, 16'hFFFF);
    send_request(hat_pkg::OP_SET_HEAT, T_MAX - 63'd1000, 1'b1, 16'd0);
    send_request(hat_pkg::OP_CHECK, T_MAX, 1'b0, 16'd0);
    send_request(hat_pkg::OP_SET_HEAT, T_MAX, 1'b0, 16'd0);
  endtask

  // Heating sessions with random content and time steps near minute boundaries.
  task automatic test_random_sessions(input int count, input logic en,
                                      input logic [15:0] smin, input logic [62:0] base);
    int          pick;
    logic [1:0]  op;
    logic        req;
    logic [15:0] mins;
    logic [63:0] span;
    set_safety(en, smin);
    now_us = base;
    for (int k = 0; k < count; k++) begin
      // Halfway through, hold off until the pipeline is empty.
      if (k == count / 2) begin
        wait_drained();
      end
      case ($urandom_range(3))
        0: span = 64'd0;
        1: span = 64'($urandom_range(120000000));
        2: span = 64'($urandom_range(3, 1)) * MIN_US - 64'd1 + 64'($urandom_range(2));
        default: span = 64'($urandom_range(1000));
      endcase
      now_us = later(now_us, span);
      pick   = $urandom_range(99);
      req    = ($urandom_range(3) != 0);
      mins   = 16'($urandom);
      if (pick < 5) begin
        op  = 2'($urandom);
        req = 1'($urandom);
      end else if (pick < 40) begin
        op = hat_pkg::OP_CHECK;
      end else if (pick < 60) begin
        op = hat_pkg::OP_SET_HEAT;
      end else if (pick < 75) begin
        op = hat_pkg::OP_SET_TIMER;
        case ($urandom_range(9))
          0: mins = 16'd0;
          8: mins = 16'hFFFF;
          9: mins = 16'($urandom);
          default: mins = 16'($urandom_range(4, 1));
        endcase
      end else begin
        op = hat_pkg::OP_STATUS;
      end
      send_request(op, now_us, req, mins);
    end
  endtask

  // Result side: random stalls, and each status item checked against the oldest prediction.
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[2:1], m_axis_tdata[3], m_axis_tdata[4],
               m_axis_tdata[20:5]};
        if (expected_status.size() == 0) begin
          note_mismatch($sformatf("status item %h with no request outstanding", got));
        end else begin
          want = expected_status.pop_front();
          if (got.heating != want.heating)
            note_mismatch($sformatf("heating_active expected %0d got %0d",
                                    want.heating, got.heating));
          if (got.reason != want.reason)
            note_mismatch($sformatf("off_reason expected %0d got %0d",
                                    want.reason, got.reason));
          if (got.armed != want.armed)
            note_mismatch($sformatf("timer_armed expected %0d got %0d",
                                    want.armed, got.armed));
          if (got.rem_valid != want.rem_valid)
            note_mismatch($sformatf("remaining_valid expected %0d got %0d",
                                    want.rem_valid, got.rem_valid));
          if (got.rem_min != want.rem_min)
            note_mismatch($sformatf("remaining_minutes expected %0d got %0d",
                                    want.rem_min, got.rem_min));
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_user_timer();
    test_safety_limit();
    test_saturation();
    test_random_sessions(260, 1'b0, 16'd0, 63'd1);
    // A long stretch with neither side idling.
    steady = 1'b1;
    test_random_sessions(260, 1'b1, 16'd3, {1'b0, 30'($urandom), 32'($urandom)});
    steady = 1'b0;
    test_random_sessions(260, 1'b1, 16'd1, T_MAX - 63'd30000000000);
    test_random_sessions(260, 1'b1, 16'hFFFF, 63'd5);
    test_random_sessions(260, 1'b1, 16'd0, 63'd7);
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
